// ----- hw/rtl/nlds_pkg.sv -----
// ----------------------------------------------------------------------------
// nlds_pkg: shared types, constants and helpers of the no-leap date adder
// Calendar constants, reciprocal constants for the constant dividers, error
// codes and the month table lookups.
// ----------------------------------------------------------------------------
package nlds_pkg;

	// error codes
	typedef logic [1:0] err_t;
	localparam err_t ERR_NONE = 2'd0;
	localparam err_t ERR_NEG  = 2'd1;
	localparam err_t ERR_OVF  = 2'd2;

	localparam int unsigned MONTHS = 12;

	localparam logic [24:0] SECS_PER_YEAR = 25'd31536000;
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam logic [26:0] TWO_YEARS     = 27'd63072000;

	// first second count whose year no longer fits 16 bits (65536 years)
	localparam logic [47:0] YEAR_LIMIT = 48'(SECS_PER_YEAR) << 16;

	// year estimate: (tot >> 24) * floor(2^34 / (SECS_PER_YEAR / 128)) >> 17,
	// low by at most two years
	localparam int unsigned YR_ODD   = 31536000 / 128;
	localparam logic [16:0] YR_RECIP = 17'((64'd1 << 34) / YR_ODD);

	// exact quotients by rounded-up reciprocals
	localparam logic [18:0] DAY_RECIP = 19'(((64'd1 << 28) + 675 - 1) / 675);   // /675, x < 2^18
	localparam logic [15:0] MIN_RECIP = 16'(((64'd1 << 19) + 15 - 1) / 15);     // /15,  x < 2^15
	localparam logic [13:0] HR_RECIP  = 14'(((64'd1 << 21) + 225 - 1) / 225);   // /225, x < 2^13

	typedef logic [8:0] doy_t;

	// day of year at the end of each month
	localparam doy_t MONTH_END [MONTHS] = '{
		9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
	};

	typedef struct packed {
		logic [3:0] month;
		logic [4:0] mday;
	} date_split_t;

	// days in the year before the first of the month; months above 12 saturate
	function automatic doy_t days_before(input logic [3:0] month);
		doy_t d;
		case (month) inside
			4'd0, 4'd1:    d = '0;
			[4'd12:4'd15]: d = MONTH_END[10];
			default:       d = MONTH_END[month - 4'd2];
		endcase
		return d;
	endfunction

	// zero-based day of year to month and day of month
	function automatic date_split_t month_split(input doy_t doy);
		date_split_t r;
		r.month = 4'(MONTHS);
		for (int i = MONTHS - 1; i >= 0; i--) begin
			if (doy < MONTH_END[i]) begin
				r.month = 4'(i + 1);
			end
		end
		r.mday = 5'(doy - days_before(r.month) + 9'd1);
		return r;
	endfunction

endpackage

// ----- hw/rtl/nlds_if.sv -----
// ----------------------------------------------------------------------------
// nlds_if: valid/ready channels of the no-leap date adder
// Start channel carries a date and a signed second delta, result channel the
// resulting date and an error code.
// ----------------------------------------------------------------------------
interface nlds_start_if;
	logic               valid;
	logic               ready;
	logic [15:0]        start_year;
	logic [3:0]         start_month;
	logic [4:0]         start_day;
	logic [4:0]         start_hour;
	logic [5:0]         start_minute;
	logic [5:0]         start_second;
	logic signed [47:0] delta_seconds;

	modport source (
		output valid, start_year, start_month, start_day, start_hour,
		output start_minute, start_second, delta_seconds,
		input  ready
	);
	modport sink (
		input  valid, start_year, start_month, start_day, start_hour,
		input  start_minute, start_second, delta_seconds,
		output ready
	);
endinterface

interface nlds_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_year;
	logic [3:0]  result_month;
	logic [4:0]  result_day;
	logic [4:0]  result_hour;
	logic [5:0]  result_minute;
	logic [5:0]  result_second;
	logic [1:0]  error_code;

	modport source (
		output valid, result_year, result_month, result_day, result_hour,
		output result_minute, result_second, error_code,
		input  ready
	);
	modport sink (
		input  valid, result_year, result_month, result_day, result_hour,
		input  result_minute, result_second, error_code,
		output ready
	);
endinterface

// ----- hw/rtl/noleap_date_add_seconds.sv -----
// ----------------------------------------------------------------------------
// noleap_date_add_seconds: add signed seconds to a date, 365-day calendar
// Flattens the start date to seconds, adds the delta and splits the sum back
// into year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// One result beat for every start beat, in order. The block is a ten-stage
// pipeline (input register, eight compute stages, output register) and takes
// a new beat every cycle unless a stall backs up to the input register.
// Throughput is one beat per cycle while the result side is not stalled,
// set by the per-stage handshake: a stage loads whenever it is empty or the
// stage after it moves, so a stalled result side stops only the full stages
// and bubbles collapse.
// The year is found by a reciprocal estimate (low by at most two) plus a
// compare-and-subtract fix-up; day, hour and minute come from exact
// reciprocal multiplies. A negative sum gives error code 1, a year above
// 65535 gives error code 2; both return all date fields zero. Month codes
// above 12 count as December, and day, hour, minute and second are taken
// linearly with their weights, so out-of-range values carry over.
// ----------------------------------------------------------------------------
module noleap_date_add_seconds (
	input  logic                 clk,
	input  logic                 arst_n,
	nlds_start_if.sink           start_date,
	nlds_result_if.source        result_date
);

	localparam int NSTG = 10;

	// stage valids and load enables
	logic [NSTG:1] vld_q;
	logic [NSTG:1] adv;

	assign adv[NSTG] = ~vld_q[NSTG] | result_date.ready;
	for (genvar k = 1; k < NSTG; k++) begin : g_adv
		assign adv[k] = ~vld_q[k] | adv[k+1];
	end

	assign start_date.ready = adv[1];
	assign result_date.valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= start_date.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ---- s1: input register
	logic [15:0]        year_s1;
	logic [3:0]         month_s1;
	logic [4:0]         day_s1;
	logic [4:0]         hour_s1;
	logic [5:0]         minute_s1;
	logic [5:0]         second_s1;
	logic signed [47:0] delta_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			year_s1   <= start_date.start_year;
			month_s1  <= start_date.start_month;
			day_s1    <= start_date.start_day;
			hour_s1   <= start_date.start_hour;
			minute_s1 <= start_date.start_minute;
			second_s1 <= start_date.start_second;
			delta_s1  <= start_date.delta_seconds;
		end
	end

	// ---- s2: year seconds and seconds into the start year (may be -1 day)
	logic signed [10:0] days_c;
	logic signed [25:0] soy_c;
	logic [40:0]        year_secs_c;

	assign days_c = $signed(11'(nlds_pkg::days_before(month_s1)) + 11'(day_s1) - 11'd1);
	assign soy_c  = $signed(26'(days_c) * 26'(nlds_pkg::SECS_PER_DAY)
		+ 26'(hour_s1) * 26'(nlds_pkg::SECS_PER_HOUR)
		+ 26'(minute_s1) * 26'(nlds_pkg::SECS_PER_MIN)
		+ 26'(second_s1));
	assign year_secs_c = 41'(year_s1) * 41'(nlds_pkg::SECS_PER_YEAR);

	logic [40:0]        year_secs_s2;
	logic signed [25:0] soy_s2;
	logic signed [47:0] delta_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			year_secs_s2 <= year_secs_c;
			soy_s2       <= soy_c;
			delta_s2     <= delta_s1;
		end
	end

	// ---- s3: total seconds, range checks
	logic signed [48:0] tot_c;
	nlds_pkg::err_t     err_c;

	assign tot_c = $signed(49'(year_secs_s2)) + 49'(soy_s2) + 49'(delta_s2);

	always_comb begin
		if (tot_c[48]) begin
			err_c = nlds_pkg::ERR_NEG;
		end else if (tot_c[47:0] >= nlds_pkg::YEAR_LIMIT) begin
			err_c = nlds_pkg::ERR_OVF;
		end else begin
			err_c = nlds_pkg::ERR_NONE;
		end
	end

	logic [40:0]    tot_s3;
	nlds_pkg::err_t err_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			tot_s3 <= tot_c[40:0];
			err_s3 <= err_c;
		end
	end

	// ---- s4: year estimate, never above the true year, at most two below
	logic [33:0] yq_prod_c;

	assign yq_prod_c = 34'(tot_s3[40:24]) * 34'(nlds_pkg::YR_RECIP);

	logic [15:0]    q0_s4;
	logic [40:0]    tot_s4;
	nlds_pkg::err_t err_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			q0_s4  <= yq_prod_c[32:17];
			tot_s4 <= tot_s3;
			err_s4 <= err_s3;
		end
	end

	// ---- s5: remainder against the estimate, below three years
	logic [26:0] r_c;

	assign r_c = 27'(tot_s4 - 41'(q0_s4) * 41'(nlds_pkg::SECS_PER_YEAR));

	logic [26:0]    r_s5;
	logic [15:0]    q0_s5;
	nlds_pkg::err_t err_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			r_s5   <= r_c;
			q0_s5  <= q0_s4;
			err_s5 <= err_s4;
		end
	end

	// ---- s6: fix-up to the exact year
	logic [15:0] ny_c;
	logic [24:0] remy_c;

	always_comb begin
		if (r_s5 >= nlds_pkg::TWO_YEARS) begin
			ny_c   = q0_s5 + 16'd2;
			remy_c = 25'(r_s5 - nlds_pkg::TWO_YEARS);
		end else if (r_s5 >= 27'(nlds_pkg::SECS_PER_YEAR)) begin
			ny_c   = q0_s5 + 16'd1;
			remy_c = 25'(r_s5 - 27'(nlds_pkg::SECS_PER_YEAR));
		end else begin
			ny_c   = q0_s5;
			remy_c = r_s5[24:0];
		end
	end

	logic [15:0]    ny_s6;
	logic [24:0]    remy_s6;
	nlds_pkg::err_t err_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			ny_s6   <= ny_c;
			remy_s6 <= remy_c;
			err_s6  <= err_s5;
		end
	end

	// ---- s7: day of year, seconds/86400 as (x >> 7) / 675
	logic [36:0] dq_prod_c;

	assign dq_prod_c = 37'(remy_s6[24:7]) * 37'(nlds_pkg::DAY_RECIP);

	nlds_pkg::doy_t doy_s7;
	logic [24:0]    remy_s7;
	logic [15:0]    ny_s7;
	nlds_pkg::err_t err_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			doy_s7  <= dq_prod_c[36:28];
			remy_s7 <= remy_s6;
			ny_s7   <= ny_s6;
			err_s7  <= err_s6;
		end
	end

	// ---- s8: seconds of day, month and day of month
	logic [16:0]           sod_c;
	nlds_pkg::date_split_t split_c;

	assign sod_c   = 17'(remy_s7 - 25'(doy_s7) * 25'(nlds_pkg::SECS_PER_DAY));
	assign split_c = nlds_pkg::month_split(doy_s7);

	logic [16:0]           sod_s8;
	nlds_pkg::date_split_t split_s8;
	logic [15:0]           ny_s8;
	nlds_pkg::err_t        err_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			sod_s8   <= sod_c;
			split_s8 <= split_c;
			ny_s8    <= ny_s7;
			err_s8   <= err_s7;
		end
	end

	// ---- s9: minute of day (x >> 2) / 15 and hour (x >> 4) / 225
	logic [30:0] mq_prod_c;
	logic [26:0] hq_prod_c;

	assign mq_prod_c = 31'(sod_s8[16:2]) * 31'(nlds_pkg::MIN_RECIP);
	assign hq_prod_c = 27'(sod_s8[16:4]) * 27'(nlds_pkg::HR_RECIP);

	logic [10:0]           mod_s9;
	logic [4:0]            hour_s9;
	logic [16:0]           sod_s9;
	nlds_pkg::date_split_t split_s9;
	logic [15:0]           ny_s9;
	nlds_pkg::err_t        err_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			mod_s9   <= mq_prod_c[29:19];
			hour_s9  <= hq_prod_c[25:21];
			sod_s9   <= sod_s8;
			split_s9 <= split_s8;
			ny_s9    <= ny_s8;
			err_s9   <= err_s8;
		end
	end

	// ---- s10: minute, second; output register, zeroed on error
	logic [5:0] minute_c;
	logic [5:0] second_c;

	assign minute_c = 6'(mod_s9 - 11'(hour_s9) * 11'(nlds_pkg::SECS_PER_MIN));
	assign second_c = 6'(sod_s9 - 17'(mod_s9) * 17'(nlds_pkg::SECS_PER_MIN));

	logic [15:0]    year_s10;
	logic [3:0]     month_s10;
	logic [4:0]     day_s10;
	logic [4:0]     hour_s10;
	logic [5:0]     minute_s10;
	logic [5:0]     second_s10;
	nlds_pkg::err_t err_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			err_s10 <= err_s9;
			if (err_s9 != nlds_pkg::ERR_NONE) begin
				year_s10   <= '0;
				month_s10  <= '0;
				day_s10    <= '0;
				hour_s10   <= '0;
				minute_s10 <= '0;
				second_s10 <= '0;
			end else begin
				year_s10   <= ny_s9;
				month_s10  <= split_s9.month;
				day_s10    <= split_s9.mday;
				hour_s10   <= hour_s9;
				minute_s10 <= minute_c;
				second_s10 <= second_c;
			end
		end
	end

	assign result_date.result_year   = year_s10;
	assign result_date.result_month  = month_s10;
	assign result_date.result_day    = day_s10;
	assign result_date.result_hour   = hour_s10;
	assign result_date.result_minute = minute_s10;
	assign result_date.result_second = second_s10;
	assign result_date.error_code    = err_s10;

endmodule

// ----- hw/rtl/nlds_checker.sv -----
// ----------------------------------------------------------------------------
// nlds_checker: port-level checks of the no-leap date adder
// Result hold under stall, error beats carry zero fields, valid dates stay
// in range and within the month length.
// ----------------------------------------------------------------------------
module nlds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] result_year,
	input logic [3:0]  result_month,
	input logic [4:0]  result_day,
	input logic [4:0]  result_hour,
	input logic [5:0]  result_minute,
	input logic [5:0]  result_second,
	input logic [1:0]  error_code
);

	logic ok_beat;
	assign ok_beat = result_valid && (error_code == nlds_pkg::ERR_NONE);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable(result_year) && $stable(result_month) && $stable(result_day)
			&& $stable(result_hour) && $stable(result_minute)
			&& $stable(result_second) && $stable(error_code))
		else $error("result beat changed while stalled");

	// error beats carry all-zero date fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (error_code != nlds_pkg::ERR_NONE) |->
			(result_year == '0) && (result_month == '0) && (result_day == '0)
			&& (result_hour == '0) && (result_minute == '0) && (result_second == '0))
		else $error("error beat with nonzero date fields");

	// good beats carry a normalized time and month
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		ok_beat |-> (result_month >= 4'd1) && (result_month <= 4'd12)
			&& (result_day >= 5'd1) && (result_hour < 5'd24)
			&& (result_minute < 6'd60) && (result_second < 6'd60))
		else $error("result field out of range");

	// day fits the month of a no-leap year
	a_mlen: assert property (@(posedge clk) disable iff (!arst_n)
		ok_beat |-> ((result_month == 4'd2) ? (result_day <= 5'd28) :
			((result_month == 4'd4) || (result_month == 4'd6)
				|| (result_month == 4'd9) || (result_month == 4'd11))
				? (result_day <= 5'd30) : (result_day <= 5'd31)))
		else $error("day beyond month length");

endmodule

bind noleap_date_add_seconds nlds_checker u_nlds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_date.valid),
	.result_ready  (result_date.ready),
	.result_year   (result_date.result_year),
	.result_month  (result_date.result_month),
	.result_day    (result_date.result_day),
	.result_hour   (result_date.result_hour),
	.result_minute (result_date.result_minute),
	.result_second (result_date.result_second),
	.error_code    (result_date.error_code)
);
